// ===== rtl/version_string_parse_compare_macros.svh =====
// Assertion macros for the version string parse/compare block.
// Assumes the asserting module has clk and active-low rst_n in scope.
`ifndef VERSION_STRING_PARSE_COMPARE_MACROS_SVH
`define VERSION_STRING_PARSE_COMPARE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define VSPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vspc assertion failed");
// Next-cycle implication, disabled during reset
`define VSPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vspc assertion failed");
`else
`define VSPC_ASSERT_SAME(label, ante, cons)
`define VSPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/vspc_pkg.sv =====
// Package for the version string parse/compare block: sizes, character
// codes, parse phases, per-slot state types and small helper functions.
package vspc_pkg;

    localparam int PART_COUNT = 4;
    localparam int NUM_WIDTH  = 16;
    localparam int PART_IDX_W = $clog2(PART_COUNT + 1);
    localparam int PART_SEL_W = (PART_COUNT > 1) ? $clog2(PART_COUNT) : 1;

    localparam logic [NUM_WIDTH-1:0] NUM_MAX = '1;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_UP_V  = 8'h56;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_V  = 8'h76;

    // Label texts, left-justified in five bytes
    localparam logic [39:0] TXT_ALPHA = "alpha";
    localparam logic [39:0] TXT_PRE   = {"pre", 16'h0000};
    localparam logic [39:0] TXT_BETA  = {"beta", 8'h00};
    localparam logic [39:0] TXT_RC    = {"rc", 24'h000000};

    typedef enum logic [3:0] {
        PH_START,
        PH_AFTER_V,
        PH_NUM,
        PH_DOT,
        PH_LABEL,
        PH_IN_LABEL,
        PH_LABEL_END,
        PH_AFTER_LSEP,
        PH_PRE_NUM,
        PH_FAIL
    } phase_t;

    typedef enum logic [1:0] {
        RANK_ALPHA,
        RANK_PRE,
        RANK_BETA,
        RANK_RC
    } rank_t;

    typedef logic [PART_COUNT-1:0][NUM_WIDTH-1:0] parts_t;

    // Working state of one slot's parser
    typedef struct packed {
        phase_t                phase;
        logic [PART_IDX_W-1:0] part_idx;
        parts_t                parts;
        logic                  fin;
        rank_t                 rank;
        logic [2:0]            lpos;
        logic [NUM_WIDTH-1:0]  pre_num;
    } slot_state_t;

    // Latched result of a slot's latest ended string
    typedef struct packed {
        parts_t               parts;
        logic                 fin;
        rank_t                rank;
        logic [NUM_WIDTH-1:0] num;
        logic                 ok;
    } held_t;

    localparam slot_state_t WORK_CLEAR = '{
        phase:    PH_START,
        part_idx: '0,
        parts:    '0,
        fin:      1'b1,
        rank:     RANK_ALPHA,
        lpos:     '0,
        pre_num:  '0
    };

    localparam held_t HELD_CLEAR = '{
        parts: '0,
        fin:   1'b0,
        rank:  RANK_ALPHA,
        num:   '0,
        ok:    1'b0
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c | 8'h20) : c;
    endfunction

    // v*10 + digit, saturating at NUM_MAX
    function automatic logic [NUM_WIDTH-1:0] accumulate(
        input logic [NUM_WIDTH-1:0] v,
        input logic [7:0]           c
    );
        logic [NUM_WIDTH+3:0] r;
        r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{NUM_WIDTH{1'b0}}, c[3:0]};
        if (r > {4'b0000, NUM_MAX})
            return NUM_MAX;
        return r[NUM_WIDTH-1:0];
    endfunction

    function automatic logic [2:0] label_len(input rank_t rk);
        logic [2:0] n;
        case (rk)
            RANK_ALPHA: n = 3'd5;
            RANK_PRE:   n = 3'd3;
            RANK_BETA:  n = 3'd4;
            RANK_RC:    n = 3'd2;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

    // Character of a label at a position; zero past the end
    function automatic logic [7:0] label_char(input rank_t rk, input logic [2:0] pos);
        logic [39:0] txt;
        logic [39:0] sh;
        case (rk)
            RANK_ALPHA: txt = TXT_ALPHA;
            RANK_PRE:   txt = TXT_PRE;
            RANK_BETA:  txt = TXT_BETA;
            RANK_RC:    txt = TXT_RC;
            default:    txt = '0;
        endcase
        sh = txt << {pos, 3'b000};
        return sh[39:32];
    endfunction

endpackage

// ===== rtl/vspc_if.sv =====
// Handshake channels of the version string parse/compare block.
// Depends on nothing; valid/ready with payload, one word per handshake.
interface vspc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] ch;

    modport source (output valid, output op, output ch, input ready);
    modport sink   (input valid, input op, input ch, output ready);
endinterface

interface vspc_out_if;
    logic valid;
    logic ready;
    logic slot;
    logic valid_version;
    logic prerelease;
    logic candidate_newer;

    modport source (output valid, output slot, output valid_version,
                    output prerelease, output candidate_newer, input ready);
    modport sink   (input valid, input slot, input valid_version,
                    input prerelease, input candidate_newer, output ready);
endinterface

// ===== rtl/vspc_parser.sv =====
// Next-state logic of one slot's version string parser, one character.
// Depends on vspc_pkg.
module vspc_parser
    import vspc_pkg::*;
(
    input  slot_state_t cur,
    input  logic [7:0]  ch,
    output slot_state_t nxt
);

    logic [7:0]            lc;
    logic                  digit;
    logic                  in_range;
    logic [PART_SEL_W-1:0] idx_sel;
    logic [NUM_WIDTH-1:0]  part_val;
    logic                  part_wr;
    logic                  do_begin;
    logic                  do_label;
    logic                  do_pre;
    logic                  lbl_hit;
    rank_t                 lbl_rank;

    always_comb
    begin
        lc       = to_lower(ch);
        digit    = is_digit(ch);
        in_range = cur.part_idx < PART_IDX_W'(PART_COUNT);
        idx_sel  = cur.part_idx[PART_SEL_W-1:0];

        // First letter of a label picks its rank
        lbl_hit  = 1'b1;
        lbl_rank = RANK_ALPHA;
        case (lc)
            CH_LO_A: lbl_rank = RANK_ALPHA;
            CH_LO_P: lbl_rank = RANK_PRE;
            CH_LO_B: lbl_rank = RANK_BETA;
            CH_LO_R: lbl_rank = RANK_RC;
            default: lbl_hit  = 1'b0;
        endcase

        nxt      = cur;
        part_val = accumulate(cur.parts[idx_sel], ch);
        part_wr  = 1'b0;
        do_begin = 1'b0;
        do_label = 1'b0;
        do_pre   = 1'b0;

        // Phase transitions
        case (cur.phase)
            PH_START:
            begin
                if ((ch == CH_SPACE) || (ch == CH_TAB))
                    nxt.phase = PH_START;
                else if ((ch == CH_LO_V) || (ch == CH_UP_V))
                    nxt.phase = PH_AFTER_V;
                else if (digit)
                    do_begin = 1'b1;
                else
                    nxt.phase = PH_FAIL;
            end
            PH_AFTER_V:
            begin
                if (digit)
                    do_begin = 1'b1;
                else
                    nxt.phase = PH_FAIL;
            end
            PH_NUM:
            begin
                if (digit)
                begin
                    part_wr = in_range;
                end
                else
                begin
                    if (in_range)
                        nxt.part_idx = cur.part_idx + 1'b1;
                    if (ch == CH_DOT)
                        nxt.phase = PH_DOT;
                    else if (is_sep(ch))
                        nxt.phase = PH_LABEL;
                    else
                        do_label = 1'b1;
                end
            end
            PH_DOT:
            begin
                if (digit)
                    do_begin = 1'b1;
                else
                    do_label = 1'b1;
            end
            PH_LABEL:
            begin
                do_label = 1'b1;
            end
            PH_IN_LABEL:
            begin
                if (lc != label_char(cur.rank, cur.lpos))
                begin
                    nxt.phase = PH_FAIL;
                end
                else
                begin
                    nxt.lpos = cur.lpos + 1'b1;
                    if (cur.lpos + 3'd1 == label_len(cur.rank))
                        nxt.phase = PH_LABEL_END;
                end
            end
            PH_LABEL_END:
            begin
                if (is_sep(ch))
                    nxt.phase = PH_AFTER_LSEP;
                else
                    do_pre = 1'b1;
            end
            PH_AFTER_LSEP, PH_PRE_NUM:
            begin
                do_pre = 1'b1;
            end
            default:
            begin
                nxt.phase = PH_FAIL;
            end
        endcase

        // Start of a new version part
        if (do_begin)
        begin
            part_val  = {{(NUM_WIDTH-4){1'b0}}, ch[3:0]};
            part_wr   = in_range;
            nxt.phase = PH_NUM;
        end

        // Start of a label
        if (do_label)
        begin
            if (lbl_hit)
            begin
                nxt.rank  = lbl_rank;
                nxt.lpos  = 3'd1;
                nxt.fin   = 1'b0;
                nxt.phase = PH_IN_LABEL;
            end
            else
            begin
                nxt.phase = PH_FAIL;
            end
        end

        // Pre-release number digits
        if (do_pre)
        begin
            if (digit)
            begin
                nxt.pre_num = accumulate(cur.pre_num, ch);
                nxt.phase   = PH_PRE_NUM;
            end
            else
            begin
                nxt.phase = PH_FAIL;
            end
        end

        // Write the current part
        for (int i = 0; i < PART_COUNT; i++)
        begin
            if (part_wr && (cur.part_idx == PART_IDX_W'(i)))
                nxt.parts[i] = part_val;
        end
    end

endmodule

// ===== rtl/vspc_compare.sv =====
// Ordering of two latched versions: parts, finished over pre-release,
// label rank, then pre-release number. Depends on vspc_pkg.
module vspc_compare
    import vspc_pkg::*;
(
    input  held_t cand,
    input  held_t curr,
    output logic  newer
);

    logic gt;

    // Tie-break chain from the least significant key upward
    always_comb
    begin
        if (cand.fin != curr.fin)
            gt = cand.fin;
        else if (cand.rank != curr.rank)
            gt = cand.rank > curr.rank;
        else
            gt = cand.num > curr.num;

        for (int i = PART_COUNT - 1; i >= 0; i--)
        begin
            if (cand.parts[i] != curr.parts[i])
                gt = cand.parts[i] > curr.parts[i];
        end
    end

    assign newer = cand.ok && curr.ok && gt;

endmodule

// ===== rtl/version_string_parse_compare.sv =====
// Version string parse and compare, top level.
// Depends on vspc_pkg, vspc_if, vspc_parser, vspc_compare and the macro header.
//
// Usage: characters of two version strings arrive on the chars channel, one
// byte per word, with op selecting the slot (0 candidate, 1 current). Slots
// may be interleaved freely. A NUL byte ends a slot's string; that word, and
// only that word, produces one result word on the result channel: the slot,
// whether the string parsed, whether it carries a pre-release label, and
// whether the latest ended candidate orders above the latest ended current.
// Order: a taken word waits in the input register, then is parsed into the
// slot state; for a NUL the result is registered with that same update.
// Throughput: one word per cycle unless a NUL stalls on a waiting result; the
// parse/compare logic between the input and result registers is combinational.
// Stall: while a result waits, further characters keep flowing; a second NUL
// waits in the input register and chars.ready drops until result is taken.
// Reset: both slots return to the start of a string and hold no parsed
// version, so candidate_newer reads 0 until both slots have ended a string.
`include "version_string_parse_compare_macros.svh"

module version_string_parse_compare
    import vspc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    vspc_in_if.sink           chars,
    vspc_out_if.source        result
);

    // Input register
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_op_reg;
    logic [7:0]  s1_ch_reg;

    // Per-slot working and latched state
    slot_state_t work_reg [2];
    slot_state_t work_next [2];
    held_t       held_reg [2];
    held_t       held_next [2];

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic        out_slot_reg;
    logic        out_ok_reg;
    logic        out_pre_reg;
    logic        out_newer_reg;

    logic        chars_accept;
    logic        s1_is_nul;
    logic        s1_fire;
    logic        res_load;
    logic        ends_ok;
    slot_state_t cur_work;
    slot_state_t parsed;
    held_t       new_held;
    held_t       cand_h;
    held_t       curr_h;
    logic        newer;

    assign cur_work = work_reg[s1_op_reg];

    vspc_parser u_parser (
        .cur (cur_work),
        .ch  (s1_ch_reg),
        .nxt (parsed)
    );

    // Latched view of the ending string
    always_comb
    begin
        ends_ok = (cur_work.phase == PH_NUM) || (cur_work.phase == PH_LABEL_END) ||
                  (cur_work.phase == PH_AFTER_LSEP) || (cur_work.phase == PH_PRE_NUM);
        new_held.parts = cur_work.parts;
        new_held.fin   = ends_ok && cur_work.fin;
        new_held.rank  = (ends_ok && !cur_work.fin) ? cur_work.rank : RANK_ALPHA;
        new_held.num   = (ends_ok && !cur_work.fin) ? cur_work.pre_num : '0;
        new_held.ok    = ends_ok;
        cand_h = s1_op_reg ? held_reg[0] : new_held;
        curr_h = s1_op_reg ? new_held : held_reg[1];
    end

    vspc_compare u_compare (
        .cand  (cand_h),
        .curr  (curr_h),
        .newer (newer)
    );

    // Handshake and next-state control
    always_comb
    begin
        s1_is_nul    = s1_ch_reg == CH_NUL;
        s1_fire      = s1_valid_reg && (!s1_is_nul || !out_valid_reg || result.ready);
        res_load     = s1_fire && s1_is_nul;
        chars.ready  = !s1_valid_reg || s1_fire;
        chars_accept = chars.valid && chars.ready;

        s1_valid_next  = chars_accept || (s1_valid_reg && !s1_fire);
        out_valid_next = (out_valid_reg && !result.ready) || res_load;

        work_next = work_reg;
        held_next = held_reg;
        if (s1_fire)
        begin
            if (s1_is_nul)
            begin
                work_next[s1_op_reg] = WORK_CLEAR;
                held_next[s1_op_reg] = new_held;
            end
            else
            begin
                work_next[s1_op_reg] = parsed;
            end
        end
    end

    // Control and slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            work_reg[0]   <= WORK_CLEAR;
            work_reg[1]   <= WORK_CLEAR;
            held_reg[0]   <= HELD_CLEAR;
            held_reg[1]   <= HELD_CLEAR;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            work_reg      <= work_next;
            held_reg      <= held_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (chars_accept)
        begin
            s1_op_reg <= chars.op;
            s1_ch_reg <= chars.ch;
        end
        if (res_load)
        begin
            out_slot_reg  <= s1_op_reg;
            out_ok_reg    <= ends_ok;
            out_pre_reg   <= ends_ok && !cur_work.fin;
            out_newer_reg <= newer;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.slot            = out_slot_reg;
    assign result.valid_version   = out_ok_reg;
    assign result.prerelease      = out_pre_reg;
    assign result.candidate_newer = out_newer_reg;

    // Checks
    `VSPC_ASSERT_NEXT(a_nul_gives_result, res_load, out_valid_reg)
    `VSPC_ASSERT_SAME(a_pre_needs_ok, out_valid_reg && out_pre_reg, out_ok_reg)
    `VSPC_ASSERT_SAME(a_newer_needs_both, out_valid_reg && out_newer_reg,
                      held_reg[0].ok && held_reg[1].ok)
    `VSPC_ASSERT_NEXT(a_nul_restarts_slot, res_load,
                      work_reg[$past(s1_op_reg)].phase == PH_START)
    `VSPC_ASSERT_NEXT(a_stalled_nul_waits,
                      s1_valid_reg && s1_is_nul && out_valid_reg && !result.ready,
                      s1_valid_reg && s1_is_nul)

endmodule
